// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DGWQ_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dgwq assertion failed");

// Next-cycle implication, disabled during reset.
`define DGWQ_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dgwq assertion failed");

`endif

// ===== rtl/dgwq_pkg.sv =====
// Package for the device grant wait queues: sizes, codes, types and helpers.
// No dependencies.
package dgwq_pkg;

   // Sizes
   localparam int DEVICES     = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int OP_W        = 2;
   localparam int ID_W        = 8;
   localparam int DEV_W       = 4;
   localparam int STATUS_W    = 3;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DEV_SEL_W   = (DEVICES > 1) ? $clog2(DEVICES) : 1;
   localparam int SLOTS       = DEVICES * QUEUE_DEPTH;
   localparam int ADDR_W      = $clog2(SLOTS);

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE     = 2'd0,
      OP_RELEASE     = 2'd1,
      OP_RELEASE_ALL = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_GRANTED    = 3'd0,
      STAT_QUEUED     = 3'd1,
      STAT_DUPLICATE  = 3'd2,
      STAT_FULL       = 3'd3,
      STAT_RELEASED   = 3'd4,
      STAT_NOT_FOUND  = 3'd5,
      STAT_BAD_DEVICE = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_SH_RD,
      S_SH_WR,
      S_REMOVE,
      S_HEAD_RD,
      S_HEAD_WT,
      S_NEXT_DEV,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [ID_W-1:0]  requester;
      logic [DEV_W-1:0] device_index;
   } req_item_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                wake_valid;
      logic [ID_W-1:0]     wake_requester;
      logic [DEV_W-1:0]    wake_device;
      logic                last;
   } result_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [ID_W-1:0]   wdata;
      logic [ADDR_W-1:0] raddr;
   } ram_ctl_type;

   // Flat slot address of queue dev, position idx
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [DEV_W-1:0] dev,
                                                   input logic [CNT_W-1:0] idx);
      logic [ADDR_W:0] a;
      a = (ADDR_W+1)'(dev) * (ADDR_W+1)'(QUEUE_DEPTH) + (ADDR_W+1)'(idx);
      return a[ADDR_W-1:0];
   endfunction

   function automatic result_type make_result(input status_type st,
                                              input logic wv,
                                              input logic [ID_W-1:0] wr,
                                              input logic [DEV_W-1:0] wd,
                                              input logic lst);
      result_type r;
      r.status         = st;
      r.wake_valid     = wv;
      r.wake_requester = wr;
      r.wake_device    = wd;
      r.last           = lst;
      return r;
   endfunction

endpackage

// ===== rtl/dgwq_if.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on dgwq_pkg.
interface dgwq_req_if;
   import dgwq_pkg::*;
   logic             valid;
   logic             ready;
   logic [OP_W-1:0]  op;
   logic [ID_W-1:0]  requester;
   logic [DEV_W-1:0] device_index;

   modport source (output valid, output op, output requester, output device_index,
                   input ready);
   modport sink (input valid, input op, input requester, input device_index,
                 output ready);
endinterface

interface dgwq_rsp_if;
   import dgwq_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                wake_valid;
   logic [ID_W-1:0]     wake_requester;
   logic [DEV_W-1:0]    wake_device;
   logic                last;

   modport source (output valid, output status, output wake_valid,
                   output wake_requester, output wake_device, output last,
                   input ready);
   modport sink (input valid, input status, input wake_valid,
                 input wake_requester, input wake_device, input last,
                 output ready);
endinterface

// ===== rtl/dgwq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dgwq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/dgwq_seq.sv =====
// Sequencer: walks queue slots through one compare path and the slot RAM.
// Depends on dgwq_pkg; drives an external dgwq_ram.
module dgwq_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dgwq_pkg::req_item_type req_item,
   output logic                   res_valid,
   input  logic                   res_ready,
   output dgwq_pkg::result_type   res,
   output dgwq_pkg::ram_ctl_type  ram_ctl,
   input  logic [dgwq_pkg::ID_W-1:0] ram_rdata
);
   import dgwq_pkg::*;

   state_type        state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [DEV_W-1:0] dev_ff, dev_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   result_type       res_ff, res_in;
   logic [CNT_W-1:0] counts_ff [DEVICES];
   logic [CNT_W-1:0] counts_in [DEVICES];
   logic [CNT_W-1:0] cur_cnt;
   logic             bad_dev;
   logic             match;

   assign cur_cnt = counts_ff[dev_ff[DEV_SEL_W-1:0]];
   assign bad_dev = (DEV_W+1)'(req_item.device_index) >= (DEV_W+1)'(DEVICES);
   // shared compare unit
   assign match   = (ram_rdata == id_ff);
   assign res     = res_ff;

   // state and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int d = 0; d < DEVICES; d++) begin
            counts_ff[d] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         counts_ff <= counts_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      id_ff  <= id_in;
      dev_ff <= dev_in;
      idx_ff <= idx_in;
      res_ff <= res_in;
   end

   // next state and outputs
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      dev_in        = dev_ff;
      idx_in        = idx_ff;
      res_in        = res_ff;
      counts_in     = counts_ff;
      req_ready     = 1'b0;
      res_valid     = 1'b0;
      ram_ctl.we    = 1'b0;
      ram_ctl.waddr = slot_addr(dev_ff, idx_ff);
      ram_ctl.wdata = id_ff;
      ram_ctl.raddr = slot_addr(dev_ff, idx_ff);

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in  = req_item.op;
               id_in  = req_item.requester;
               idx_in = '0;
               case (req_item.op) inside
                  OP_ACQUIRE, OP_RELEASE: begin
                     if (bad_dev) begin
                        res_in   = make_result(STAT_BAD_DEVICE, 1'b0, '0, '0, 1'b1);
                        state_in = S_EMIT;
                     end else begin
                        dev_in   = req_item.device_index;
                        state_in = S_READ;
                     end
                  end
                  OP_RELEASE_ALL: begin
                     dev_in   = '0;
                     state_in = S_READ;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         // end of queue reached: id absent; otherwise fetch the next slot
         S_READ: begin
            if (idx_ff == cur_cnt) begin
               case (op_ff)
                  OP_ACQUIRE: begin
                     if (cur_cnt == CNT_W'(QUEUE_DEPTH)) begin
                        res_in = make_result(STAT_FULL, 1'b0, '0, '0, 1'b1);
                     end else begin
                        ram_ctl.we    = 1'b1;
                        ram_ctl.waddr = slot_addr(dev_ff, cur_cnt);
                        counts_in[dev_ff[DEV_SEL_W-1:0]] = cur_cnt + CNT_W'(1);
                        res_in = make_result((cur_cnt == '0) ? STAT_GRANTED : STAT_QUEUED,
                                             1'b0, '0, '0, 1'b1);
                     end
                     state_in = S_EMIT;
                  end
                  OP_RELEASE: begin
                     res_in   = make_result(STAT_NOT_FOUND, 1'b0, '0, '0, 1'b1);
                     state_in = S_EMIT;
                  end
                  default: state_in = S_NEXT_DEV;
               endcase
            end else begin
               state_in = S_CMP;
            end
         end

         S_CMP: begin
            if (match) begin
               if (op_ff == OP_ACQUIRE) begin
                  res_in   = make_result(STAT_DUPLICATE, 1'b0, '0, '0, 1'b1);
                  state_in = S_EMIT;
               end else if (idx_ff + CNT_W'(1) < cur_cnt) begin
                  state_in = S_SH_RD;
               end else begin
                  state_in = S_REMOVE;
               end
            end else begin
               idx_in   = idx_ff + CNT_W'(1);
               state_in = S_READ;
            end
         end

         // close the gap one slot at a time
         S_SH_RD: begin
            ram_ctl.raddr = slot_addr(dev_ff, idx_ff + CNT_W'(1));
            state_in      = S_SH_WR;
         end

         S_SH_WR: begin
            ram_ctl.we    = 1'b1;
            ram_ctl.wdata = ram_rdata;
            idx_in        = idx_ff + CNT_W'(1);
            state_in      = (idx_ff + CNT_W'(2) < cur_cnt) ? S_SH_RD : S_REMOVE;
         end

         S_REMOVE: begin
            counts_in[dev_ff[DEV_SEL_W-1:0]] = cur_cnt - CNT_W'(1);
            if (cur_cnt != CNT_W'(1)) begin
               state_in = S_HEAD_RD;
            end else if (op_ff == OP_RELEASE) begin
               res_in   = make_result(STAT_RELEASED, 1'b0, '0, '0, 1'b1);
               state_in = S_EMIT;
            end else begin
               state_in = S_NEXT_DEV;
            end
         end

         S_HEAD_RD: begin
            ram_ctl.raddr = slot_addr(dev_ff, '0);
            state_in      = S_HEAD_WT;
         end

         S_HEAD_WT: begin
            res_in   = make_result(STAT_RELEASED, 1'b1, ram_rdata, dev_ff,
                                   op_ff == OP_RELEASE);
            state_in = S_EMIT;
         end

         // release all: step to the next device or close
         S_NEXT_DEV: begin
            if (dev_ff == DEV_W'(DEVICES - 1)) begin
               res_in   = make_result(STAT_RELEASED, 1'b0, '0, '0, 1'b1);
               state_in = S_EMIT;
            end else begin
               dev_in   = dev_ff + DEV_W'(1);
               idx_in   = '0;
               state_in = S_READ;
            end
         end

         S_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = res_ff.last ? S_IDLE : S_NEXT_DEV;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/device_grant_wait_queues_top.sv =====
// Top level of the device grant wait queues: sequencer, slot RAM, output register.
// Depends on dgwq_pkg, dgwq_if, dgwq_ram and dgwq_seq.
//
//   channel   dir   handshake      payload
//   req_chan  in    valid/ready    op, requester, device_index
//   rsp_chan  out   valid/ready    status, wake_valid, wake_requester, wake_device, last
//
// One item at a time; each slot is compared in a read state and a compare state through
// the shared compare path and slot RAM port, and each slot is shifted in a read state
// and a write state when a gap is closed; then the head is read and the result emitted.
// The scan stops at the match and the shift covers the rest; release all walks every
// device queue in turn. Reset is synchronous and clears all queue counts at once. A
// stalled result waits in the output register.
module device_grant_wait_queues_top (
   input logic      clock,
   input logic      reset,
   dgwq_req_if.sink   req_chan,
   dgwq_rsp_if.source rsp_chan
);
   import dgwq_pkg::*;

   req_item_type     req_item;
   result_type       seq_res;
   logic             seq_res_valid;
   logic             seq_res_ready;
   ram_ctl_type      ram_ctl;
   logic [ID_W-1:0]  ram_rdata;
   logic             seq_req_ready;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_data_ff, rsp_data_in;
   logic             res_xfer;

   assign req_item.op           = req_chan.op;
   assign req_item.requester    = req_chan.requester;
   assign req_item.device_index = req_chan.device_index;
   assign req_chan.ready        = seq_req_ready;

   dgwq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (seq_req_ready),
      .req_item  (req_item),
      .res_valid (seq_res_valid),
      .res_ready (seq_res_ready),
      .res       (seq_res),
      .ram_ctl   (ram_ctl),
      .ram_rdata (ram_rdata)
   );

   dgwq_ram #(
      .WIDTH (ID_W),
      .DEPTH (SLOTS)
   ) u_slots (
      .clock (clock),
      .we    (ram_ctl.we),
      .waddr (ram_ctl.waddr),
      .wdata (ram_ctl.wdata),
      .raddr (ram_ctl.raddr),
      .rdata (ram_rdata)
   );

   // output register: takes a result when empty or being drained
   assign seq_res_ready = !rsp_valid_ff || rsp_chan.ready;
   assign res_xfer      = seq_res_valid && seq_res_ready;
   assign rsp_valid_in  = res_xfer || (rsp_valid_ff && !rsp_chan.ready);
   assign rsp_data_in   = res_xfer ? seq_res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_data_ff.status;
   assign rsp_chan.wake_valid     = rsp_data_ff.wake_valid;
   assign rsp_chan.wake_requester = rsp_data_ff.wake_requester;
   assign rsp_chan.wake_device    = rsp_data_ff.wake_device;
   assign rsp_chan.last           = rsp_data_ff.last;

endmodule

// ===== rtl/dgwq_checker.sv =====
// Port-level checks for the device grant wait queues, bound to the top level.
// Depends on dgwq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dgwq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [dgwq_pkg::OP_W-1:0]     req_op,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [dgwq_pkg::STATUS_W-1:0] rsp_status,
   input logic                          rsp_wake_valid,
   input logic [dgwq_pkg::ID_W-1:0]     rsp_wake_requester,
   input logic [dgwq_pkg::DEV_W-1:0]    rsp_wake_device,
   input logic                          rsp_last
);
   import dgwq_pkg::*;

   // a valid op keeps the block busy for at least the next cycle
   `DGWQ_ASSERT_NEXT(a_busy_after_op, clock, reset, req_valid && req_ready && (req_op == OP_ACQUIRE || req_op == OP_RELEASE || req_op == OP_RELEASE_ALL), !req_ready)
   // no wake: wake fields are zero
   `DGWQ_ASSERT_IMPL(a_wake_zero, clock, reset, rsp_valid && !rsp_wake_valid, rsp_wake_requester == '0 && rsp_wake_device == '0)
   // wakes only come from releases
   `DGWQ_ASSERT_IMPL(a_wake_released, clock, reset, rsp_valid && rsp_wake_valid, rsp_status == STAT_RELEASED)
   // only release results can be followed by more
   `DGWQ_ASSERT_IMPL(a_single_last, clock, reset, rsp_valid && rsp_status != STAT_RELEASED, rsp_last)
   // stalled result holds
   `DGWQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_status, rsp_wake_valid, rsp_wake_requester, rsp_wake_device, rsp_last}))

endmodule

bind device_grant_wait_queues_top dgwq_checker u_dgwq_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_op             (req_chan.op),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_status         (rsp_chan.status),
   .rsp_wake_valid     (rsp_chan.wake_valid),
   .rsp_wake_requester (rsp_chan.wake_requester),
   .rsp_wake_device    (rsp_chan.wake_device),
   .rsp_last           (rsp_chan.last)
);

// ===== test/tb_device_grant_wait_queues_top.sv =====
// Testbench for device_grant_wait_queues_top: directed and random acquire/release traffic
// checked against a behavioral model of the per-device wait queues.
// Depends on dgwq_pkg, dgwq_if and the RTL of the top level.
`timescale 1ns / 1ps

import dgwq_pkg::*;

// Behavioral model of the wait queues and store of awaited responses
class grant_scoreboard;
   logic [ID_W-1:0] slot_ids [DEVICES][QUEUE_DEPTH];
   int              depth_used [DEVICES];
   result_type      awaited [$];
   int              mismatches;

   function void clear();
      foreach (depth_used[d]) depth_used[d] = 0;
      awaited.delete();
      mismatches = 0;
   endfunction

   function int outstanding();
      return awaited.size();
   endfunction

   // Position of id in the queue of dev, -1 when absent
   function int find_pos(int dev, logic [ID_W-1:0] id);
      int i;
      for (i = 0; i < depth_used[dev]; i++)
         if (slot_ids[dev][i] == id) return i;
      return -1;
   endfunction

   // Drop the entry at pos and close the gap
   function void remove_at(int dev, int pos);
      int j;
      for (j = pos; j + 1 < depth_used[dev]; j++)
         slot_ids[dev][j] = slot_ids[dev][j + 1];
      depth_used[dev]--;
   endfunction

   function void add_outcome(status_type st, logic wv, logic [ID_W-1:0] wr,
                             logic [DEV_W-1:0] wd, logic lst);
      result_type r;
      r.status         = st;
      r.wake_valid     = wv;
      r.wake_requester = wr;
      r.wake_device    = wd;
      r.last           = lst;
      awaited.push_back(r);
   endfunction

   // Update the queues for one accepted request and note what it should produce
   function void note_request(req_item_type r);
      int dev;
      int pos;
      int d;
      dev = r.device_index;
      case (r.op)
         OP_ACQUIRE, OP_RELEASE: begin
            if (dev >= DEVICES) begin
               add_outcome(STAT_BAD_DEVICE, 1'b0, '0, '0, 1'b1);
            end else begin
               pos = find_pos(dev, r.requester);
               if (r.op == OP_ACQUIRE) begin
                  // duplicate wins over full
                  if (pos >= 0) begin
                     add_outcome(STAT_DUPLICATE, 1'b0, '0, '0, 1'b1);
                  end else if (depth_used[dev] >= QUEUE_DEPTH) begin
                     add_outcome(STAT_FULL, 1'b0, '0, '0, 1'b1);
                  end else begin
                     slot_ids[dev][depth_used[dev]] = r.requester;
                     depth_used[dev]++;
                     add_outcome(depth_used[dev] == 1 ? STAT_GRANTED : STAT_QUEUED,
                                 1'b0, '0, '0, 1'b1);
                  end
               end else if (pos < 0) begin
                  add_outcome(STAT_NOT_FOUND, 1'b0, '0, '0, 1'b1);
               end else begin
                  remove_at(dev, pos);
                  if (depth_used[dev] != 0)
                     add_outcome(STAT_RELEASED, 1'b1, slot_ids[dev][0], DEV_W'(dev), 1'b1);
                  else
                     add_outcome(STAT_RELEASED, 1'b0, '0, '0, 1'b1);
               end
            end
         end
         OP_RELEASE_ALL: begin
            // one wake per changed, non-empty queue, then the closing response
            for (d = 0; d < DEVICES; d++) begin
               pos = find_pos(d, r.requester);
               if (pos >= 0) begin
                  remove_at(d, pos);
                  if (depth_used[d] != 0)
                     add_outcome(STAT_RELEASED, 1'b1, slot_ids[d][0], DEV_W'(d), 1'b0);
               end
            end
            add_outcome(STAT_RELEASED, 1'b0, '0, '0, 1'b1);
         end
         default: ; // unused code: no effect, no response
      endcase
   endfunction

   // Compare one response transfer with the oldest awaited one
   function void check_result(result_type got);
      result_type want;
      if (awaited.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected response: status %0d wake %0b/%0d/%0d last %0b",
                  $time, got.status, got.wake_valid, got.wake_requester,
                  got.wake_device, got.last);
      end else begin
         want = awaited.pop_front();
         if (got.status !== want.status || got.wake_valid !== want.wake_valid ||
             got.wake_requester !== want.wake_requester ||
             got.wake_device !== want.wake_device || got.last !== want.last) begin
            mismatches++;
            $display("%0t: mismatch: expected status %0d wake %0b/%0d/%0d last %0b, got status %0d wake %0b/%0d/%0d last %0b",
                     $time, want.status, want.wake_valid, want.wake_requester,
                     want.wake_device, want.last, got.status, got.wake_valid,
                     got.wake_requester, got.wake_device, got.last);
         end
      end
   endfunction
endclass

module tb_device_grant_wait_queues_top;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS     = 400;
   localparam int CALM_TAIL        = 60;
   localparam int BLOCK_ITEMS      = 50;
   localparam int LONG_HOLD_AT     = 150;
   localparam int LONG_HOLD_CYCLES = 500;
   // release all can walk every queue
   localparam int DRAIN_CYCLES     = DEVICES * (2 * QUEUE_DEPTH + 5) + 50;
   localparam int CYCLE_LIMIT      = 1_500_000;

   logic clock;
   logic reset;

   dgwq_req_if req_chan ();
   dgwq_rsp_if rsp_chan ();

   device_grant_wait_queues_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   grant_scoreboard sb = new();

   int   sender_gap_pct;
   int   receiver_stall_pct;
   logic long_hold_due;
   int   cycle_count;

   req_item_type seen_req;
   result_type   seen_rsp;

   // Clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL device_grant_wait_queues_top");
         $finish;
      end
   end

   // Monitor: sample both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            seen_req.op           = req_chan.op;
            seen_req.requester    = req_chan.requester;
            seen_req.device_index = req_chan.device_index;
            sb.note_request(seen_req);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen_rsp.status         = rsp_chan.status;
            seen_rsp.wake_valid     = rsp_chan.wake_valid;
            seen_rsp.wake_requester = rsp_chan.wake_requester;
            seen_rsp.wake_device    = rsp_chan.wake_device;
            seen_rsp.last           = rsp_chan.last;
            sb.check_result(seen_rsp);
         end
      end
   end

   // Response side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end else if (receiver_stall_pct != 0 &&
                      $urandom_range(1, 100) <= receiver_stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one request; entered and left just after a falling edge
   task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [DEV_W-1:0] dev);
      if (sender_gap_pct != 0 && $urandom_range(1, 100) <= sender_gap_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.op           <= op;
      req_chan.requester    <= id;
      req_chan.device_index <= dev;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [DEV_W-1:0] pick_device(int dev_span);
      if (DEVICES < 16 && $urandom_range(0, 15) == 0)
         return DEV_W'($urandom_range(DEVICES, 15));
      return DEV_W'($urandom_range(0, dev_span - 1));
   endfunction

   // Stimulus
   initial begin
      int count;
      int k;
      int roll;
      int dev_span;
      int id_span;
      int acquire_pct;
      logic [OP_W-1:0] op;

      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.op           = OP_ACQUIRE;
      req_chan.requester    = '0;
      req_chan.device_index = '0;
      long_hold_due         = 1'b0;
      cycle_count           = 0;
      sender_gap_pct        = 20;
      receiver_stall_pct    = 10;
      sb.clear();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: fill device 0 with ids 0, 255, 1..14 to reach full depth
      send_item(OP_ACQUIRE, 8'd0, 4'd0);
      send_item(OP_ACQUIRE, 8'd255, 4'd0);
      for (k = 1; k < QUEUE_DEPTH - 1; k++)
         send_item(OP_ACQUIRE, ID_W'(k), 4'd0);
      send_item(OP_ACQUIRE, 8'd255, 4'd0);    // duplicate on a full queue
      send_item(OP_ACQUIRE, 8'd100, 4'd0);    // full
      send_item(OP_ACQUIRE, 8'd5, 4'd15);     // bad device, top code
      send_item(OP_RELEASE, 8'd5, DEV_W'(DEVICES)); // bad device, first out of range
      send_item(OP_RELEASE, 8'd200, 4'd0);    // not queued
      send_item(OP_RELEASE, 8'd7, 4'd0);      // waiter leaves, head unchanged
      send_item(OP_RELEASE, 8'd0, 4'd0);      // head leaves
      send_item(OP_ACQUIRE, 8'd255, DEV_W'(DEVICES - 1));
      send_item(OP_RELEASE_ALL, 8'd255, 4'd0);
      send_item(OP_RELEASE_ALL, 8'd200, 4'd15); // nothing held
      send_item(OP_UNUSED, 8'd255, 4'd15);    // ignored code

      // Random: blocks of differing traffic shape and idling density
      dev_span    = DEVICES;
      id_span     = 8;
      acquire_pct = 50;
      count       = 0;
      while (count < RANDOM_ITEMS) begin
         if (count % BLOCK_ITEMS == 0) begin
            case ($urandom_range(0, 2))
               0: begin  // crowd a couple of devices so queues fill
                  dev_span    = (DEVICES < 2) ? DEVICES : 2;
                  id_span     = 24;
                  acquire_pct = 70;
               end
               1: begin
                  dev_span    = DEVICES;
                  id_span     = 8;
                  acquire_pct = 45;
               end
               default: begin
                  dev_span    = DEVICES;
                  id_span     = 256;
                  acquire_pct = 55;
               end
            endcase
            sender_gap_pct     = $urandom_range(0, 2) * 20;
            receiver_stall_pct = $urandom_range(0, 2) * 12;
         end
         if (count >= RANDOM_ITEMS - CALM_TAIL) begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 0;
         end
         if (count == LONG_HOLD_AT)
            long_hold_due = 1'b1;

         roll = $urandom_range(0, 99);
         if (roll < 4)
            op = OP_UNUSED;
         else if (roll < 4 + acquire_pct)
            op = OP_ACQUIRE;
         else if (roll < 88)
            op = OP_RELEASE;
         else
            op = OP_RELEASE_ALL;

         send_item(op, ID_W'($urandom_range(0, id_span - 1)), pick_device(dev_span));
         if (op != OP_UNUSED)
            count++;
      end
      req_chan.valid <= 1'b0;

      // Drain, then allow the longest walk to finish
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("PASS device_grant_wait_queues_top");
      end else begin
         $display("FAIL device_grant_wait_queues_top");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dgwq_pkg.sv
rtl/dgwq_if.sv
rtl/dgwq_ram.sv
rtl/dgwq_seq.sv
rtl/device_grant_wait_queues_top.sv
rtl/dgwq_checker.sv
test/tb_device_grant_wait_queues_top.sv
